@@ hw/rtl/double_ended_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Short forms for same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation codes, status codes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   // Value reported for an end of an empty deque.
   localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } deq_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring store of DEPTH signed words with a head index and a word count.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_func, req_push_value
//   rsp      out        rsp_valid / rsp_ready  popped, front, rear, occupancy,
//                                              is_empty, status
//
// A transaction passes through the states IDLE, READ and LOAD: acceptance
// with the push write, the two-port memory read of the new ends, and the
// load of the result register, which waits while an untaken result is held.
// The result register lets a new transaction be accepted while a result waits.
// Reset clears the state, head index, count and result valid flag; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [deq_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [deq_pkg::DATA_W-1:0]   req_push_value,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic signed [deq_pkg::DATA_W-1:0]   rsp_popped_value,
   output      logic signed [deq_pkg::DATA_W-1:0]   rsp_front_value,
   output      logic signed [deq_pkg::DATA_W-1:0]   rsp_rear_value,
   output      logic [CNT_W-1:0]                    rsp_occupancy,
   output      logic                                rsp_is_empty,
   output      logic [deq_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = CNT_W + 1;

   // Folds a sum below twice DEPTH back into the ring.
   function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
      return t[IDX_W-1:0];
   endfunction

   logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];

   deq_pkg::deq_state_type state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Cached end words; meaningful in the idle state whenever the count is nonzero.
   logic signed [deq_pkg::DATA_W-1:0] front_ff, front_in;
   logic signed [deq_pkg::DATA_W-1:0] rear_ff, rear_in;

   // Per-transaction results held until the result load.
   logic signed [deq_pkg::DATA_W-1:0] popped_ff, popped_in;
   logic [deq_pkg::STATUS_W-1:0]      status_ff, status_in;

   logic signed [deq_pkg::DATA_W-1:0] rd_front_ff, rd_rear_ff;

   logic                              out_valid_ff, out_valid_in;
   logic signed [deq_pkg::DATA_W-1:0] out_popped_ff, out_popped_in;
   logic signed [deq_pkg::DATA_W-1:0] out_front_ff, out_front_in;
   logic signed [deq_pkg::DATA_W-1:0] out_rear_ff, out_rear_in;
   logic [CNT_W-1:0]                  out_count_ff, out_count_in;
   logic [deq_pkg::STATUS_W-1:0]      out_status_ff, out_status_in;

   logic                              mem_we;
   logic [IDX_W-1:0]                  mem_waddr;
   logic [IDX_W-1:0]                  last_idx;
   logic                              accept;
   logic                              is_full;
   logic                              is_void;
   logic                              load;
   logic [IDX_W-1:0]                  head_dec;
   logic [IDX_W-1:0]                  head_inc;

   assign req_ready = (state_ff == deq_pkg::ST_IDLE);
   assign accept  = req_valid && req_ready;
   assign is_full = (count_ff == CNT_W'(DEPTH));
   assign is_void = (count_ff == '0);
   assign load    = (state_ff == deq_pkg::ST_LOAD) && (!out_valid_ff || rsp_ready);

   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign last_idx = is_void ? head_ff
                             : wrap(SUM_W'(head_ff) + SUM_W'(count_ff) - 1'b1);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff;
      out_popped_in = out_popped_ff;
      out_front_in  = out_front_ff;
      out_rear_in   = out_rear_ff;
      out_count_in  = out_count_ff;
      out_status_in = out_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = head_dec;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               popped_in = '0;
               status_in = deq_pkg::STATUS_OK;
               case (req_func)
                  deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_REAR: begin
                     if (is_full) begin
                        status_in = deq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                        if (req_func == deq_pkg::FUNC_PUSH_FRONT) begin
                           head_in = head_dec;
                        end else begin
                           mem_waddr = wrap(SUM_W'(head_ff) + SUM_W'(count_ff));
                        end
                     end
                  end
                  deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_POP_REAR: begin
                     if (is_void) begin
                        status_in = deq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_func == deq_pkg::FUNC_POP_FRONT) begin
                           popped_in = front_ff;
                           head_in   = head_inc;
                        end else begin
                           popped_in = rear_ff;
                        end
                     end
                  end
                  default: begin
                     // Query and the unused codes leave the head, count and store alone.
                  end
               endcase
               state_in = deq_pkg::ST_READ;
            end
         end
         deq_pkg::ST_READ: begin
            state_in = deq_pkg::ST_LOAD;
         end
         deq_pkg::ST_LOAD: begin
            if (load) begin
               front_in      = rd_front_ff;
               rear_in       = rd_rear_ff;
               out_valid_in  = 1'b1;
               out_popped_in = popped_ff;
               out_front_in  = is_void ? deq_pkg::EMPTY_MARK : rd_front_ff;
               out_rear_in   = is_void ? deq_pkg::EMPTY_MARK : rd_rear_ff;
               out_count_in  = count_ff;
               out_status_in = status_ff;
               state_in      = deq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      out_popped_ff <= out_popped_in;
      out_front_ff  <= out_front_in;
      out_rear_ff   <= out_rear_in;
      out_count_ff  <= out_count_in;
      out_status_ff <= out_status_in;
   end

   // Ring store: one write port, two read ports with registered data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == deq_pkg::ST_READ) begin
         rd_front_ff <= mem[head_ff];
         rd_rear_ff  <= mem[last_idx];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_popped_value = out_popped_ff;
   assign rsp_front_value  = out_front_ff;
   assign rsp_rear_value   = out_rear_ff;
   assign rsp_occupancy    = out_count_ff;
   assign rsp_is_empty     = (out_count_ff == '0);
   assign rsp_status       = out_status_ff;

`include "double_ended_queue_assert.svh"

   `DEQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `DEQ_ASSERT_SAME(a_head_bound, clock, reset, 1'b1, head_ff < IDX_W'(DEPTH - 1) || head_ff == IDX_W'(DEPTH - 1), "head outside ring")
   `DEQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second transaction accepted while one is in flight")
   `DEQ_ASSERT_NEXT(a_full_push, clock, reset, req_valid && req_ready && is_full && (req_func == deq_pkg::FUNC_PUSH_FRONT || req_func == deq_pkg::FUNC_PUSH_REAR), status_ff == deq_pkg::STATUS_PUSH_FULL && count_ff == CNT_W'(DEPTH), "push on full deque not dropped")

endmodule

`default_nettype wire
